FILE: hdl/assert_macros.svh
// Assertion macros shared by the hull block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a boolean condition never occurs outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/chgw_pkg.sv
// Types and constants for the gift wrapping convex hull block.
`timescale 1ns / 1ps
package chgw_pkg;

   localparam int MAX_POINTS_DEF   = 64;
   localparam int MAX_POINTS_LIMIT = 64;
   localparam int MIN_HULL_POINTS  = 3;
   localparam int COORD_W          = 16;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int PROD_W           = 2 * DIFF_W;
   localparam int JOB_CNT_W        = $clog2(MAX_POINTS_LIMIT + 1);
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic STATUS_HULL    = 1'b0;
   localparam logic STATUS_TOO_FEW = 1'b1;

   // One incoming point
   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic                      last_point;
   } req_type;

   // One emitted result
   typedef struct packed {
      logic signed [COORD_W-1:0] hull_x;
      logic signed [COORD_W-1:0] hull_y;
      logic                      status;
      logic                      overflowed;
      logic                      end_of_hull;
   } rsp_type;

   // Stored point
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   // Finished set handed from capture to walker
   typedef struct packed {
      logic [JOB_CNT_W-1:0] count;
      logic                 overflowed;
   } job_type;

   // Walker control seen by the capture side
   typedef struct packed {
      logic busy;
      logic job_pop;
   } walk_ctl_type;

   typedef enum logic [3:0] {
      W_IDLE,
      W_FEW,
      W_FIND_RD,
      W_FIND_CMP,
      W_CAND_RD,
      W_CAND_LD,
      W_SCAN_RD,
      W_SCAN_MUL,
      W_SCAN_DEC,
      W_EMIT
   } walk_state_type;

endpackage

FILE: hdl/chgw_store.sv
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps
module chgw_store import chgw_pkg::*; #(
   parameter int DEPTH = MAX_POINTS_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  point_type     wr_point,
   input  logic [AW-1:0] rd_addr,
   output point_type     rd_point
);

   point_type mem [DEPTH];
   point_type rd_point_ff;

   // Write incoming points
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_point;
      end
   end

   // Register read data
   always_ff @(posedge clock) begin
      rd_point_ff <= mem[rd_addr];
   end

   assign rd_point = rd_point_ff;

endmodule

FILE: hdl/chgw_front.sv
// Capture side: stores points, counts them and queues finished sets.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chgw_front import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  req_type       req_item,
   output logic          store_wr_en,
   output logic [AW-1:0] store_wr_addr,
   output point_type     store_wr_point,
   input  walk_ctl_type  walk,
   output logic          job_valid,
   output job_type       job
);

   logic [CW-1:0]          point_count_ff, point_count_in;
   logic                   overflow_ff, overflow_in;
   job_type                q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] q_wr_ptr_ff, q_wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] q_rd_ptr_ff, q_rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] q_count_ff, q_count_in;
   logic                   accept;
   logic                   has_room;
   logic [CW-1:0]          count_after;
   logic                   overflow_after;
   logic                   q_push;

   // Hold off requests while a set waits or is being walked: the store is shared
   assign full     = (q_count_ff != '0) || walk.busy;
   assign accept   = push && !full;
   assign has_room = point_count_ff < CW'(MAX_POINTS);

   assign store_wr_en      = accept && has_room;
   assign store_wr_addr    = point_count_ff[AW-1:0];
   assign store_wr_point.x = req_item.px;
   assign store_wr_point.y = req_item.py;

   assign count_after    = has_room ? point_count_ff + CW'(1) : point_count_ff;
   assign overflow_after = overflow_ff || !has_room;
   assign q_push         = accept && req_item.last_point;

   // Advance the point count, drop points past capacity, clear both on the closing point
   always_comb begin
      point_count_in = point_count_ff;
      overflow_in    = overflow_ff;
      if (accept) begin
         if (req_item.last_point) begin
            point_count_in = '0;
            overflow_in    = 1'b0;
         end else begin
            point_count_in = count_after;
            overflow_in    = overflow_after;
         end
      end
   end

   // Job queue pointers
   always_comb begin
      q_wr_ptr_in = q_push ? q_wr_ptr_ff + QUEUE_PTR_W'(1) : q_wr_ptr_ff;
      q_rd_ptr_in = walk.job_pop ? q_rd_ptr_ff + QUEUE_PTR_W'(1) : q_rd_ptr_ff;
      q_count_in  = q_count_ff;
      if (q_push && !walk.job_pop) begin
         q_count_in = q_count_ff + QUEUE_CNT_W'(1);
      end else if (!q_push && walk.job_pop) begin
         q_count_in = q_count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         overflow_ff    <= 1'b0;
         q_wr_ptr_ff    <= '0;
         q_rd_ptr_ff    <= '0;
         q_count_ff     <= '0;
      end else begin
         point_count_ff <= point_count_in;
         overflow_ff    <= overflow_in;
         q_wr_ptr_ff    <= q_wr_ptr_in;
         q_rd_ptr_ff    <= q_rd_ptr_in;
         q_count_ff     <= q_count_in;
      end
   end

   // Queue entries
   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[q_wr_ptr_ff].count      <= JOB_CNT_W'(count_after);
         q_mem_ff[q_wr_ptr_ff].overflowed <= overflow_after;
      end
   end

   assign job_valid = q_count_ff != '0;
   assign job       = q_mem_ff[q_rd_ptr_ff];

   `ASSERT_HOLDS(a_count_in_range, clock, reset, point_count_ff <= CW'(MAX_POINTS), "point count past capacity")
   `ASSERT_NEVER(a_no_accept_busy, clock, reset, accept && walk.busy, "point taken during hull walk")
   `ASSERT_NEVER(a_queue_overrun, clock, reset, q_push && (q_count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)), "job queue overrun")

endmodule

FILE: hdl/chgw_back.sv
// Walk side: finds the start point, wraps the hull and emits vertices or a too-few result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chgw_back import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int AW = $clog2(MAX_POINTS),
   localparam int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   input  job_type       job,
   output walk_ctl_type  walk,
   output logic [AW-1:0] rd_addr,
   input  point_type     rd_point,
   output logic          empty,
   input  logic          pop,
   output rsp_type       rsp_item
);

   walk_state_type state_ff, state_in;

   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     ov_ff, ov_in;
   logic [CW-1:0]            k_ff, k_in;
   logic [CW-1:0]            n_ff, n_in;
   logic [AW-1:0]            start_ff, start_in;
   logic [AW-1:0]            cur_ff, cur_in;
   logic [AW-1:0]            cand_ff, cand_in;
   point_type                cur_pt_ff, cur_pt_in;
   point_type                cand_pt_ff, cand_pt_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     rsp_write;
   logic                     slot_free;
   logic                     last_k;
   logic                     take_min;
   logic [AW-1:0]            find_cur;
   logic [AW-1:0]            find_next;
   logic [AW-1:0]            cand_next;
   logic                     hull_end;
   logic                     turn_neg;
   logic [CW-1:0]            job_cnt;
   logic signed [DIFF_W-1:0] dqy, drx, dqx, dry;
   logic signed [PROD_W:0]   det;

   assign job_cnt   = job.count[CW-1:0];
   assign slot_free = !rsp_valid_ff || pop;
   assign last_k    = (k_ff + CW'(1)) == cnt_ff;

   // Leftmost search: strict compare keeps the lowest index on ties
   assign take_min  = (k_ff == '0) || (rd_point.x < cur_pt_ff.x);
   assign find_cur  = take_min ? k_ff[AW-1:0] : cur_ff;
   assign find_next = ((CW'(find_cur) + CW'(1)) == cnt_ff) ? '0 : find_cur + AW'(1);
   assign cand_next = ((CW'(cand_ff) + CW'(1)) == cnt_ff) ? '0 : cand_ff + AW'(1);

   // Walk closes at the start or after as many vertices as points
   assign hull_end  = (cand_ff == start_ff) || ((n_ff + CW'(1)) >= cnt_ff);

   // Orientation of (current, k, candidate)
   assign dqy = DIFF_W'(rd_point.y) - DIFF_W'(cur_pt_ff.y);
   assign drx = DIFF_W'(cand_pt_ff.x) - DIFF_W'(rd_point.x);
   assign dqx = DIFF_W'(rd_point.x) - DIFF_W'(cur_pt_ff.x);
   assign dry = DIFF_W'(cand_pt_ff.y) - DIFF_W'(rd_point.y);
   assign det = (PROD_W+1)'(prod_a_ff) - (PROD_W+1)'(prod_b_ff);
   assign turn_neg = det[PROD_W];

   assign rd_addr = (state_ff == W_CAND_RD) ? cand_ff : k_ff[AW-1:0];

   assign walk.busy    = state_ff != W_IDLE;
   assign walk.job_pop = (state_ff == W_IDLE) && job_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (job_valid) begin
               state_in = (job_cnt < CW'(MIN_HULL_POINTS)) ? W_FEW : W_FIND_RD;
            end
         end
         W_FEW: begin
            if (slot_free) begin
               state_in = W_IDLE;
            end
         end
         W_FIND_RD:  state_in = W_FIND_CMP;
         W_FIND_CMP: state_in = last_k ? W_CAND_RD : W_FIND_RD;
         W_CAND_RD:  state_in = W_CAND_LD;
         W_CAND_LD:  state_in = W_SCAN_RD;
         W_SCAN_RD:  state_in = W_SCAN_MUL;
         W_SCAN_MUL: state_in = W_SCAN_DEC;
         W_SCAN_DEC: state_in = last_k ? W_EMIT : W_SCAN_RD;
         W_EMIT: begin
            if (slot_free) begin
               state_in = hull_end ? W_IDLE : W_CAND_RD;
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   // Datapath and result writes
   always_comb begin
      cnt_in     = cnt_ff;
      ov_in      = ov_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      start_in   = start_ff;
      cur_in     = cur_ff;
      cand_in    = cand_ff;
      cur_pt_in  = cur_pt_ff;
      cand_pt_in = cand_pt_ff;
      prod_a_in  = prod_a_ff;
      prod_b_in  = prod_b_ff;
      rsp_write  = 1'b0;
      rsp_in     = rsp_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (job_valid) begin
               cnt_in = job_cnt;
               ov_in  = job.overflowed;
               k_in   = '0;
            end
         end
         W_FEW: begin
            if (slot_free) begin
               rsp_write          = 1'b1;
               rsp_in.hull_x      = '0;
               rsp_in.hull_y      = '0;
               rsp_in.status      = STATUS_TOO_FEW;
               rsp_in.overflowed  = ov_ff;
               rsp_in.end_of_hull = 1'b1;
            end
         end
         W_FIND_RD: begin
         end
         W_FIND_CMP: begin
            if (take_min) begin
               start_in  = k_ff[AW-1:0];
               cur_in    = k_ff[AW-1:0];
               cur_pt_in = rd_point;
            end
            k_in = k_ff + CW'(1);
            if (last_k) begin
               cand_in = find_next;
               n_in    = '0;
            end
         end
         W_CAND_RD: begin
         end
         W_CAND_LD: begin
            cand_pt_in = rd_point;
            k_in       = '0;
         end
         W_SCAN_RD: begin
         end
         W_SCAN_MUL: begin
            prod_a_in = dqy * drx;
            prod_b_in = dqx * dry;
         end
         W_SCAN_DEC: begin
            if (turn_neg) begin
               cand_in    = k_ff[AW-1:0];
               cand_pt_in = rd_point;
            end
            k_in = k_ff + CW'(1);
         end
         W_EMIT: begin
            if (slot_free) begin
               rsp_write          = 1'b1;
               rsp_in.hull_x      = cur_pt_ff.x;
               rsp_in.hull_y      = cur_pt_ff.y;
               rsp_in.status      = STATUS_HULL;
               rsp_in.overflowed  = ov_ff;
               rsp_in.end_of_hull = hull_end;
               n_in               = n_ff + CW'(1);
               cur_in             = cand_ff;
               cur_pt_in          = cand_pt_ff;
               cand_in            = cand_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: hold the result until popped
   assign rsp_valid_in = rsp_write || (rsp_valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      ov_ff      <= ov_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      start_ff   <= start_in;
      cur_ff     <= cur_in;
      cand_ff    <= cand_in;
      cur_pt_ff  <= cur_pt_in;
      cand_pt_ff <= cand_pt_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      rsp_ff     <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_ff;

   `ASSERT_HOLDS(a_scan_index, clock, reset, ((state_ff == W_SCAN_MUL) || (state_ff == W_SCAN_DEC)) |-> (k_ff < cnt_ff), "scan index past point count")
   `ASSERT_HOLDS(a_cand_index, clock, reset, (state_ff == W_SCAN_DEC) |-> (CW'(cand_ff) < cnt_ff), "candidate outside stored points")
   `ASSERT_HOLDS(a_vertex_cap, clock, reset, (state_ff == W_EMIT) |-> (n_ff < cnt_ff), "more vertices than points")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_write && rsp_valid_ff && !pop, "waiting result overwritten")

endmodule

FILE: hdl/convex_hull_gift_wrap.sv
// Convex hull by gift wrapping: top level.
// Usage: write points through push/full/req_item, one request per cycle while
// full is low. The request with last_point set closes the set and starts the
// walk; full stays high until the walk has handed its final result over.
// Results come out of a queue-style port: rsp_item is valid while empty is low
// and is taken with pop. Vertices arrive in walk order, the final one of a set
// with end_of_hull; a set of fewer than three points gives one too-few result.
// Points past MAX_POINTS are dropped and flag every result of that set.
// Walk for a set of N stored points: a leftmost search reads each stored point
// once, then each hull vertex comes from a scan over all N points, each scan
// step reading one stored point through the single store read port, forming
// its two products in two registered 17x17 multipliers and then testing the
// sign of the orientation; the vertex is emitted once its scan is done.
// Reset clears the point count, the job queue and the result register; the
// point store is not cleared, only written entries are ever used.
// When the receiver does not pop, the walk halts at its next result and the
// input side stays full.
`timescale 1ns / 1ps
module convex_hull_gift_wrap import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   localparam int AW = $clog2(MAX_POINTS);

   logic          store_wr_en;
   logic [AW-1:0] store_wr_addr;
   point_type     store_wr_point;
   logic [AW-1:0] store_rd_addr;
   point_type     store_rd_point;
   walk_ctl_type  walk;
   logic          job_valid;
   job_type       job;

   chgw_store #(
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock    (clock),
      .wr_en    (store_wr_en),
      .wr_addr  (store_wr_addr),
      .wr_point (store_wr_point),
      .rd_addr  (store_rd_addr),
      .rd_point (store_rd_point)
   );

   chgw_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_item       (req_item),
      .store_wr_en    (store_wr_en),
      .store_wr_addr  (store_wr_addr),
      .store_wr_point (store_wr_point),
      .walk           (walk),
      .job_valid      (job_valid),
      .job            (job)
   );

   chgw_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .walk      (walk),
      .rd_addr   (store_rd_addr),
      .rd_point  (store_rd_point),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: tb/sv/tb_convex_hull_gift_wrap.sv
// Testbench for the gift wrapping convex hull block: directed table, random point sets, self-check.
`timescale 1ns / 1ps
module tb_convex_hull_gift_wrap;
   import chgw_pkg::*;

   localparam int STORE_DEPTH   = MAX_POINTS_DEF;
   localparam int QUIET_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 400;
   localparam int RANDOM_ITEMS  = 108;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_NARROW,
      SHAPE_ARC,
      SHAPE_SAME
   } shape_type;

   // One directed row: the request and, where obvious, its single result
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } probe_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_item = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_item;

   // Point store and flags that mirror the block
   logic signed [COORD_W-1:0] pt_x [STORE_DEPTH];
   logic signed [COORD_W-1:0] pt_y [STORE_DEPTH];
   int unsigned   pt_count   = 0;
   bit            pt_dropped = 1'b0;
   rsp_type       fresh_hull [$];
   rsp_type       hull_due   [$];
   probe_row_type probe_rows [$];

   int  fail_count   = 0;
   int  quiet_cycles = 0;
   bit  steady_tx    = 1'b0;
   bit  steady_rx    = 1'b0;

   convex_hull_gift_wrap #(
      .MAX_POINTS(STORE_DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_item(req_item),
      .empty   (empty),
      .pop     (pop),
      .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sign of the turn p -> q -> r, exact in 64 bits
   function automatic int turn_sign(input int p, input int q, input int r);
      longint d;
      d = (longint'(pt_y[q]) - longint'(pt_y[p])) * (longint'(pt_x[r]) - longint'(pt_x[q]))
        - (longint'(pt_x[q]) - longint'(pt_x[p])) * (longint'(pt_y[r]) - longint'(pt_y[q]));
      if (d == 0) return 0;
      return (d > 0) ? 1 : -1;
   endfunction

   // Store one point; on the closing point, walk the hull into fresh_hull
   function automatic void wrap_point(input req_type r);
      int      n_pts;
      int      start;
      int      cur;
      int      cand;
      int      emitted;
      rsp_type v;
      fresh_hull = {};
      if (pt_count < STORE_DEPTH) begin
         pt_x[pt_count] = r.px;
         pt_y[pt_count] = r.py;
         pt_count++;
      end else begin
         pt_dropped = 1'b1;
      end
      if (!r.last_point) return;
      n_pts = pt_count;
      if (n_pts < MIN_HULL_POINTS) begin
         v = '{16'sd0, 16'sd0, STATUS_TOO_FEW, pt_dropped, 1'b1};
         fresh_hull.push_back(v);
      end else begin
         // leftmost point, lowest index on a tie
         start = 0;
         for (int k = 1; k < n_pts; k++)
            if (pt_x[k] < pt_x[start]) start = k;
         cur     = start;
         emitted = 0;
         do begin
            v = '{pt_x[cur], pt_y[cur], STATUS_HULL, pt_dropped, 1'b0};
            fresh_hull.push_back(v);
            emitted++;
            cand = (cur + 1) % n_pts;
            for (int k = 0; k < n_pts; k++)
               if (turn_sign(cur, k, cand) < 0) cand = k;
            cur = cand;
         end while (cur != start && emitted < n_pts);
         v = fresh_hull.pop_back();
         v.end_of_hull = 1'b1;
         fresh_hull.push_back(v);
      end
      pt_count   = 0;
      pt_dropped = 1'b0;
   endfunction

   function automatic void add_row(input int x, input int y, input bit last,
                                   input bit typed, input rsp_type want);
      probe_row_type row;
      row.item  = '{16'(x), 16'(y), last};
      row.typed = typed;
      row.want  = want;
      probe_rows.push_back(row);
   endfunction

   // Send one request, then queue what it should produce
   task automatic send_req(input req_type r, input bit typed, input rsp_type want);
      while (!steady_tx && $urandom_range(0, 99) < 33) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      wrap_point(r);
      if (typed) hull_due.push_back(want);
      else foreach (fresh_hull[i]) hull_due.push_back(fresh_hull[i]);
   endtask

   // Send a whole point set of the given shape, closing it on the final point
   task automatic send_set(input int n_pts, input shape_type shape);
      req_type r;
      int      x0;
      int      y0;
      int      step;
      int      sx;
      int      sy;
      int      rot;
      int      j;
      int      u;
      int      w;
      bit      flip;
      x0   = $urandom_range(0, 64000) - 32000;
      y0   = $urandom_range(0, 56000) - 28000;
      step = $urandom_range(1, 8);
      sx   = $urandom_range(0, 1) ? 1 : -1;
      sy   = $urandom_range(0, 1) ? 1 : -1;
      rot  = $urandom_range(0, n_pts - 1);
      flip = $urandom_range(0, 1);
      u    = $urandom;
      w    = $urandom;
      for (int i = 0; i < n_pts; i++) begin
         case (shape)
            SHAPE_WIDE: begin
               r.px = 16'($urandom);
               r.py = 16'($urandom);
            end
            SHAPE_NARROW: begin
               // tight grid: duplicates, collinear runs, ties on least x
               r.px = 16'(int'($urandom_range(0, 16)) - 8);
               r.py = 16'(int'($urandom_range(0, 16)) - 8);
            end
            SHAPE_ARC: begin
               // points on a parabola are all hull vertices
               j = (i + rot) % n_pts;
               if (flip) begin
                  r.py = 16'(x0 + sx * j * step);
                  r.px = 16'(y0 + sy * j * j);
               end else begin
                  r.px = 16'(x0 + sx * j * step);
                  r.py = 16'(y0 + sy * j * j);
               end
            end
            default: begin
               r.px = 16'(u);
               r.py = 16'(w);
            end
         endcase
         r.last_point = (i == n_pts - 1);
         send_req(r, 1'b0, '0);
      end
   endtask

   task automatic drain_hull;
      push <= 1'b0;
      while (hull_due.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t %s: expected x %0d y %0d st %0b ov %0b end %0b,",
                  $realtime, what, want.hull_x, want.hull_y, want.status, want.overflowed,
                  want.end_of_hull,
                  " got x %0d y %0d st %0b ov %0b end %0b",
                  got.hull_x, got.hull_y, got.status, got.overflowed, got.end_of_hull);
   endtask

   // Receiver: pop at random, steady during the long stretch
   always @(posedge clock) begin
      pop <= steady_rx || ($urandom_range(0, 99) >= 33);
   end

   // Check each popped result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (hull_due.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_item);
         end else begin
            want = hull_due.pop_front();
            if (rsp_item !== want) report_mismatch("result mismatch", want, rsp_item);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL convex_hull_gift_wrap");
            $finish;
         end
      end
   end

   initial begin
      int        random_sent;
      int        pick;
      int        n_pts;
      bit        overflow_done;
      shape_type shape;

      random_sent   = 0;
      overflow_done = 1'b0;

      // too-few sets, extremes, duplicates, ties on least x, collinear runs
      add_row(0, 0, 1, 1, '{16'sd0, 16'sd0, STATUS_TOO_FEW, 1'b0, 1'b1});
      add_row(32767, -32768, 0, 0, '0);
      add_row(-32768, 32767, 1, 1, '{16'sd0, 16'sd0, STATUS_TOO_FEW, 1'b0, 1'b1});
      add_row(-32768, -32768, 0, 0, '0);
      add_row(-32768, -32768, 0, 0, '0);
      add_row(-32768, -32768, 1, 0, '0);
      add_row(32767, 32767, 0, 0, '0);
      add_row(-32768, 32767, 0, 0, '0);
      add_row(-32768, -32768, 0, 0, '0);
      add_row(32767, -32768, 1, 0, '0);
      add_row(0, 0, 0, 0, '0);
      add_row(5, 5, 0, 0, '0);
      add_row(10, 10, 0, 0, '0);
      add_row(-3, -3, 1, 0, '0);
      add_row(-7, 2, 0, 0, '0);
      add_row(4, 9, 0, 0, '0);
      add_row(-7, -5, 0, 0, '0);
      add_row(1, 1, 0, 0, '0);
      add_row(6, -3, 1, 0, '0);
      add_row(-1, -1, 1, 1, '{16'sd0, 16'sd0, STATUS_TOO_FEW, 1'b0, 1'b1});
      add_row(32767, 32767, 0, 0, '0);
      add_row(32767, 32767, 1, 1, '{16'sd0, 16'sd0, STATUS_TOO_FEW, 1'b0, 1'b1});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) send_req(probe_rows[i].item, probe_rows[i].typed,
                                       probe_rows[i].want);

      // random point sets, with one overflowing set sent back to back
      while (random_sent < RANDOM_ITEMS) begin
         if (!overflow_done && random_sent >= 30) begin
            drain_hull();
            steady_tx = 1'b1;
            steady_rx = 1'b1;
            n_pts     = STORE_DEPTH + 2;
            send_set(n_pts, SHAPE_ARC);
            drain_hull();
            steady_tx     = 1'b0;
            steady_rx     = 1'b0;
            overflow_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               n_pts = $urandom_range(1, 2);
               shape = SHAPE_WIDE;
            end else if (pick < 45) begin
               n_pts = $urandom_range(3, 10);
               shape = SHAPE_NARROW;
            end else if (pick < 70) begin
               n_pts = $urandom_range(3, 10);
               shape = SHAPE_WIDE;
            end else if (pick < 92) begin
               n_pts = $urandom_range(3, 14);
               shape = SHAPE_ARC;
            end else begin
               n_pts = $urandom_range(3, 6);
               shape = SHAPE_SAME;
            end
            send_set(n_pts, shape);
         end
         random_sent += n_pts;
      end

      drain_hull();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && hull_due.size() == 0) begin
         $display("PASS convex_hull_gift_wrap");
      end else begin
         $display("FAIL convex_hull_gift_wrap");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/chgw_pkg.sv
hdl/chgw_store.sv
hdl/chgw_front.sv
hdl/chgw_back.sv
hdl/convex_hull_gift_wrap.sv
tb/sv/tb_convex_hull_gift_wrap.sv
